// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and month-length function for the calendar date stepper.
package cdad_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_MAX_YEAR   = 9999;

    localparam int IN_YEAR_BITS  = 14;
    localparam int IN_MONTH_BITS = 4;
    localparam int IN_DAY_BITS   = 5;
    localparam int IN_COUNT_BITS = 16;
    localparam int S_DATA_BITS   = 40;
    localparam int M_DATA_BITS   = 24;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAY_DEC31 = 5'd31;
    localparam logic [6:0] CENT_LAST = 7'd99;
    localparam logic [7:0] DIVISOR   = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic norm;
        logic step;
        logic flag;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cnt_zero;
        logic at_limit;
        logic out_free;
    } status_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/cdad_ctrl.sv =====
// Sequencer for load, year split, date normalization, day stepping and result hand-off.
module cdad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cdad_pkg::status_t status,
    output cdad_pkg::cmd_t    cmd
);

    cdad_pkg::state_t state_reg;
    cdad_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdad_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cdad_pkg::ST_DIV;
                end
            end
            cdad_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = cdad_pkg::ST_NORM;
                end
            end
            cdad_pkg::ST_NORM:
            begin
                state_next = cdad_pkg::ST_STEP;
            end
            cdad_pkg::ST_STEP:
            begin
                if (status.cnt_zero || status.at_limit)
                begin
                    state_next = cdad_pkg::ST_FINISH;
                end
            end
            cdad_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = cdad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            cdad_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            cdad_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            cdad_pkg::ST_NORM:
            begin
                cmd.norm = 1'b1;
            end
            cdad_pkg::ST_STEP:
            begin
                cmd.step = !status.cnt_zero && !status.at_limit;
                cmd.flag = !status.cnt_zero && status.at_limit;
            end
            cdad_pkg::ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/cdad_dp.sv =====
// Date registers, year-by-100 split, single-day stepper and output register.
module cdad_dp #(
    parameter int COUNT_BITS = cdad_pkg::DEF_COUNT_BITS,
    parameter int MAX_YEAR   = cdad_pkg::DEF_MAX_YEAR
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [cdad_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdad_pkg::M_DATA_BITS-1:0]   m_tdata,
    output logic                               m_tuser,
    input  cdad_pkg::cmd_t                     cmd,
    output cdad_pkg::status_t                  status
);

    localparam int YEAR_BITS  = ($clog2(MAX_YEAR + 1) > cdad_pkg::IN_YEAR_BITS) ?
                                $clog2(MAX_YEAR + 1) : cdad_pkg::IN_YEAR_BITS;
    localparam int CENT_BITS  = $clog2(MAX_YEAR / 100 + 1);
    localparam int CNT_BITS   = (COUNT_BITS < cdad_pkg::IN_COUNT_BITS) ?
                                COUNT_BITS : cdad_pkg::IN_COUNT_BITS;
    localparam int DCNT_BITS  = 1;
    localparam int PROD_BITS  = YEAR_BITS + 16;
    localparam int RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(MAX_YEAR);
    localparam logic [YEAR_BITS-1:0] YEAR_MIN = YEAR_BITS'(1);
    localparam logic [DCNT_BITS-1:0] DIV_LAST = DCNT_BITS'(1);

    logic [YEAR_BITS-1:0] in_year;
    logic [3:0]           in_month;
    logic [4:0]           in_day;
    logic [CNT_BITS-1:0]  in_count;
    logic [YEAR_BITS-1:0] clamp_year;
    logic [3:0]           clamp_month;

    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [3:0]           month_reg, month_next;
    logic [4:0]           day_reg, day_next;
    logic [6:0]           rem_reg, rem_next;
    logic [CENT_BITS-1:0] cent_reg, cent_next;
    logic [DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 back_reg, back_next;
    logic                 hit_reg, hit_next;
    logic [cdad_pkg::M_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_valid_reg, out_valid_next;

    logic [PROD_BITS-1:0] recip_prod;
    logic                 leap;
    logic [4:0]           cur_len;
    logic [4:0]           prev_len;
    logic                 limit_fwd;
    logic                 limit_back;

    assign in_year  = YEAR_BITS'(s_tdata[13:0]);
    assign in_month = s_tdata[17:14];
    assign in_day   = s_tdata[22:18];
    assign in_count = s_tdata[23 +: CNT_BITS];

    assign clamp_year  = (in_year < YEAR_MIN) ? YEAR_MIN :
                         (in_year > YEAR_MAX) ? YEAR_MAX : in_year;
    assign clamp_month = (in_month < cdad_pkg::MONTH_JAN) ? cdad_pkg::MONTH_JAN :
                         (in_month > cdad_pkg::MONTH_DEC) ? cdad_pkg::MONTH_DEC : in_month;

    assign recip_prod = PROD_BITS'(year_reg) * PROD_BITS'(RECIP_100);

    assign leap     = (rem_reg[1:0] == 2'd0) && ((rem_reg != 7'd0) || (cent_reg[1:0] == 2'd0));
    assign cur_len  = cdad_pkg::month_len(leap, month_reg);
    assign prev_len = cdad_pkg::month_len(leap, month_reg - 4'd1);

    assign limit_fwd  = (year_reg >= YEAR_MAX) && (month_reg == cdad_pkg::MONTH_DEC) &&
                        (day_reg == cdad_pkg::DAY_DEC31);
    assign limit_back = (year_reg <= YEAR_MIN) && (month_reg == cdad_pkg::MONTH_JAN) &&
                        (day_reg == cdad_pkg::DAY_FIRST);

    assign status.div_done = (dcnt_reg == DIV_LAST);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.at_limit = back_reg ? limit_back : limit_fwd;
    assign status.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        rem_next       = rem_reg;
        cent_next      = cent_reg;
        dcnt_next      = dcnt_reg;
        cnt_next       = cnt_reg;
        back_next      = back_reg;
        hit_next       = hit_reg;
        out_data_next  = out_data_reg;
        out_hit_next   = out_hit_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.load)
        begin
            year_next  = clamp_year;
            month_next = clamp_month;
            day_next   = in_day;
            rem_next   = '0;
            dcnt_next  = '0;
            cnt_next   = in_count;
            back_next  = s_tuser;
            hit_next   = 1'b0;
        end

        // split the year by 100: quotient first, then remainder
        if (cmd.div_step)
        begin
            if (dcnt_reg == '0)
            begin
                cent_next = recip_prod[RECIP_SHIFT +: CENT_BITS];
            end
            else
            begin
                rem_next = 7'(year_reg - YEAR_BITS'(cent_reg) * YEAR_BITS'(cdad_pkg::DIVISOR));
            end
            dcnt_next = dcnt_reg + DCNT_BITS'(1);
        end

        if (cmd.norm)
        begin
            if (day_reg < cdad_pkg::DAY_FIRST)
            begin
                day_next = cdad_pkg::DAY_FIRST;
            end
            else if (day_reg > cur_len)
            begin
                day_next = cur_len;
            end
        end

        if (cmd.flag)
        begin
            hit_next = 1'b1;
        end

        if (cmd.step)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (!back_reg)
            begin
                if (day_reg >= cur_len)
                begin
                    day_next = cdad_pkg::DAY_FIRST;
                    if (month_reg == cdad_pkg::MONTH_DEC)
                    begin
                        month_next = cdad_pkg::MONTH_JAN;
                        year_next  = year_reg + YEAR_BITS'(1);
                        if (rem_reg == cdad_pkg::CENT_LAST)
                        begin
                            rem_next  = '0;
                            cent_next = cent_reg + CENT_BITS'(1);
                        end
                        else
                        begin
                            rem_next = rem_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    day_next = day_reg + 5'd1;
                end
            end
            else
            begin
                if (day_reg > cdad_pkg::DAY_FIRST)
                begin
                    day_next = day_reg - 5'd1;
                end
                else if (month_reg > cdad_pkg::MONTH_JAN)
                begin
                    month_next = month_reg - 4'd1;
                    day_next   = prev_len;
                end
                else
                begin
                    month_next = cdad_pkg::MONTH_DEC;
                    day_next   = cdad_pkg::DAY_DEC31;
                    year_next  = year_reg - YEAR_BITS'(1);
                    if (rem_reg == '0)
                    begin
                        rem_next  = cdad_pkg::CENT_LAST;
                        cent_next = cent_reg - CENT_BITS'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg - 7'd1;
                    end
                end
            end
        end

        if (cmd.emit)
        begin
            out_data_next  = {1'b0, day_reg, month_reg, year_reg[13:0]};
            out_hit_next   = hit_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg     <= year_next;
        month_reg    <= month_next;
        day_reg      <= day_next;
        rem_reg      <= rem_next;
        cent_reg     <= cent_next;
        dcnt_reg     <= dcnt_next;
        cnt_reg      <= cnt_next;
        back_reg     <= back_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
        out_hit_reg  <= out_hit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

`ifndef SYNTHESIS
    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (year_reg >= YEAR_MIN) && (year_reg <= YEAR_MAX))
        else $error("year left its range while stepping");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (month_reg >= cdad_pkg::MONTH_JAN) && (month_reg <= cdad_pkg::MONTH_DEC))
        else $error("month left its range while stepping");

    a_split_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((32'(cent_reg) * 32'd100 + 32'(rem_reg)) == 32'(year_reg)))
        else $error("century and remainder disagree with year");

    a_day_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (day_reg >= cdad_pkg::DAY_FIRST) && (day_reg <= cur_len))
        else $error("day outside month length while stepping");
`endif

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// Top level of the Gregorian date stepper: adds or subtracts a day count from a date.
//
// Input channel s_*: one beat carries a start date, a day count and the direction
// (s_tuser high steps backward). Month and day are clamped to a valid date and the
// year to 1..MAX_YEAR before stepping. Output channel m_*: one beat per input beat
// with the resulting date; m_tuser is high when stepping stopped at year 1 or MAX_YEAR.
// From the input beat to the output beat, the year is first split by 100 with a
// reciprocal multiply, quotient first and then remainder, and the date is normalized;
// the stepper then advances exactly one day per cycle until the count runs out or a
// year limit is reached, and the finish step loads the output register once it is free.
// A year limit cuts the stepping short.
// One beat is in work at a time; a new beat is taken while the previous result still
// waits in the output register.
// Reset clears the sequencer and the output valid; no result is pending afterward.
// When the receiver stalls, the finished result holds on m_*; the next beat may be
// taken and worked on, and its result waits until the output register frees up.
module calendar_date_add_days #(
    parameter int COUNT_BITS = cdad_pkg::DEF_COUNT_BITS,
    parameter int MAX_YEAR   = cdad_pkg::DEF_MAX_YEAR
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], day_count[38:23], zero pad
    input  logic [cdad_pkg::S_DATA_BITS-1:0] s_tdata,
    // go_back
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // end_year[13:0], end_month[17:14], end_day[22:18], zero pad
    output logic [cdad_pkg::M_DATA_BITS-1:0] m_tdata,
    // range_hit
    output logic                             m_tuser
);

    cdad_pkg::cmd_t    cmd;
    cdad_pkg::status_t status;

    cdad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdad_dp #(
        .COUNT_BITS (COUNT_BITS),
        .MAX_YEAR   (MAX_YEAR)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
